/* rtl/core/ebt_pkg.sv */
package ebt_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int OP_W              = 3;
   localparam int DATA_W            = 32;

   localparam logic [OP_W-1:0] OP_SET      = 3'd0;
   localparam logic [OP_W-1:0] OP_UNSET    = 3'd1;
   localparam logic [OP_W-1:0] OP_TOGGLE   = 3'd2;
   localparam logic [OP_W-1:0] OP_ISSET    = 3'd3;
   localparam logic [OP_W-1:0] OP_ISNOTSET = 3'd4;
   localparam logic [OP_W-1:0] OP_TIMEDOUT = 3'd5;

   // Carries that ripple from the lowest cell to the highest.
   typedef struct packed {
      logic hit_seen;    // a lower cell already holds the flag
      logic hit_stale;   // the holding cell's expiry is below now
      logic free_seen;   // a lower cell is free
      logic later_seen;  // some lower valid cell expires after now
   } chain_type;

   // Update commands broadcast from the top level to every cell.
   typedef struct packed {
      logic clear_hit;    // invalidate the holding cell
      logic clear_stale;  // invalidate the holding cell if it has expired
      logic add;          // write the flag into the lowest free cell
   } ctl_type;

endpackage

/* rtl/core/ebt_cell.sv */
module ebt_cell import ebt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              capture,
   input  logic              update,
   input  logic [DATA_W-1:0] req_bit_index,
   input  logic [DATA_W-1:0] req_now,
   input  logic [DATA_W-1:0] wr_index,
   input  logic [DATA_W-1:0] wr_expiry,
   input  ctl_type           ctl,
   input  chain_type         chain_in,
   output chain_type         chain_out
);

   logic              valid_ff;
   logic              valid_in;
   logic [DATA_W-1:0] index_ff;
   logic [DATA_W-1:0] expiry_ff;
   logic              hit_ff;
   logic              stale_ff;
   logic              later_ff;
   logic              own_hit;
   logic              own_free;
   logic              write_en;

   // The cell owns the request only if no lower cell claimed it first.
   assign own_hit  = hit_ff && !chain_in.hit_seen;
   assign own_free = !valid_ff && !chain_in.free_seen;
   assign write_en = update && ctl.add && own_free;

   always_comb begin
      valid_in = valid_ff;
      if (update && own_hit && (ctl.clear_hit || (ctl.clear_stale && stale_ff))) begin
         valid_in = 1'b0;
      end
      if (write_en) begin
         valid_in = 1'b1;
      end
   end

   always_comb begin
      chain_out.hit_seen   = chain_in.hit_seen | hit_ff;
      chain_out.hit_stale  = chain_in.hit_seen ? chain_in.hit_stale : (hit_ff & stale_ff);
      chain_out.free_seen  = chain_in.free_seen | !valid_ff;
      chain_out.later_seen = chain_in.later_seen | (valid_ff & later_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         index_ff  <= wr_index;
         expiry_ff <= wr_expiry;
      end
      if (capture) begin
         hit_ff   <= valid_ff && (index_ff == req_bit_index);
         stale_ff <= expiry_ff < req_now;
         later_ff <= expiry_ff > req_now;
      end
   end

endmodule

/* rtl/core/expiring_bit_table_top.sv */
// A word accepted at one clock edge updates the table at the next edge, and its
// result strobe is high during the cycle after that.
// A new word is accepted only while busy is low; busy is high for the one cycle in which the
// carry chain through all cells settles. The result port has no stall.
// Reset is synchronous and clears every valid flag at once; no clearing pass is needed.
module expiring_bit_table_top import ebt_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [OP_W-1:0]   req_operation,
   input  logic [DATA_W-1:0] req_bit_index,
   input  logic [DATA_W-1:0] req_expire_time,
   input  logic [DATA_W-1:0] req_now,
   output logic              rsp_valid,
   output logic              rsp_answer,
   output logic              rsp_table_full
);

   // The table is a row of identical cells, one entry each. At the edge that accepts a
   // word, every cell registers its own comparisons against the request: whether it
   // holds the flag, whether its expiry is below now, and whether it is above now.
   // During the following cycle those results ripple from the lowest cell upward, so
   // that each cell learns whether a lower cell already holds the flag or is free. This
   // gives the lowest match and the lowest free entry without any central search.

   logic              busy_ff;
   logic              rsp_valid_ff;
   logic              rsp_answer_ff;
   logic              rsp_answer_in;
   logic              rsp_table_full_ff;
   logic              rsp_table_full_in;
   logic [OP_W-1:0]   op_ff;
   logic [DATA_W-1:0] index_ff;
   logic [DATA_W-1:0] expiry_ff;
   logic              accept;
   logic              found;
   logic              present;
   ctl_type           ctl;
   chain_type         chain_w [0:TABLE_ENTRIES];

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   assign chain_w[0] = '0;

   generate
      for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
         ebt_cell u_cell (
            .clock         (clock),
            .reset         (reset),
            .capture       (accept),
            .update        (busy_ff),
            .req_bit_index (req_bit_index),
            .req_now       (req_now),
            .wr_index      (index_ff),
            .wr_expiry     (expiry_ff),
            .ctl           (ctl),
            .chain_in      (chain_w[i]),
            .chain_out     (chain_w[i+1])
         );
      end
   endgenerate

   // The far end of the chain summarizes the whole table for the decision below.
   assign found   = chain_w[TABLE_ENTRIES].hit_seen;
   assign present = found && !chain_w[TABLE_ENTRIES].hit_stale;

   always_comb begin
      ctl               = '0;
      rsp_answer_in     = 1'b0;
      rsp_table_full_in = 1'b0;
      case (op_ff)
         OP_SET: begin
            ctl.add           = !found;
            rsp_table_full_in = !found && !chain_w[TABLE_ENTRIES].free_seen;
         end
         OP_UNSET: begin
            ctl.clear_hit = 1'b1;
         end
         OP_TOGGLE: begin
            ctl.clear_hit     = 1'b1;
            ctl.add           = !found;
            rsp_table_full_in = !found && !chain_w[TABLE_ENTRIES].free_seen;
         end
         OP_ISSET: begin
            // An expired flag is dropped when it is tested.
            ctl.clear_stale = 1'b1;
            rsp_answer_in   = present;
         end
         OP_ISNOTSET: begin
            ctl.clear_stale = 1'b1;
            rsp_answer_in   = !present;
         end
         OP_TIMEDOUT: begin
            rsp_answer_in = !chain_w[TABLE_ENTRIES].later_seen;
         end
         default: begin
            // Unused codes leave the table alone and answer zero.
            ctl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= accept;
         rsp_valid_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_operation;
         index_ff  <= req_bit_index;
         expiry_ff <= req_expire_time;
      end
      if (busy_ff) begin
         rsp_answer_ff     <= rsp_answer_in;
         rsp_table_full_ff <= rsp_table_full_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_answer     = rsp_answer_ff;
   assign rsp_table_full = rsp_table_full_ff;

`ifndef ASSERT_OFF
   // Every table update is followed by exactly one result word.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> rsp_valid_ff) else $error("result strobe missing after update");

   // The update phase lasts a single cycle.
   a_busy_one: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !busy_ff) else $error("busy held longer than one cycle");

   // Only an add can report a full table.
   a_full_op: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_table_full_ff) |-> (op_ff == OP_SET || op_ff == OP_TOGGLE))
      else $error("table full reported for an operation that does not add");

   // A result never both answers a test and reports a dropped add.
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_answer_ff && rsp_table_full_ff))
      else $error("answer and table full both set");
`endif

endmodule
